@@ rtl/core/fdag_pkg.sv @@
// Package for the fisheye dewarp address generator.
// Holds the register indexes, reset values, field widths and default parameters.
// It has no dependencies.
package fdag_pkg;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_DATA_W = 16;
  localparam int DIM_W      = 13;
  localparam int RADIUS_W   = 16;
  localparam int MARGIN_W   = 12;
  localparam int POS_W      = 13;
  localparam int COORD_W    = 12;
  localparam int OFF_W      = 16;
  localparam int MAG_W      = 15;
  localparam int NUM_W      = 32;
  localparam int RAD_IN_W   = 40;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_LENS_RADIUS  = 3'd2,
    REG_COL_MARGIN   = 3'd3,
    REG_ROW_MARGIN   = 3'd4
  } reg_index_t;

  localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd480;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd1500;
  localparam logic [MARGIN_W-1:0] CMARG_RST  = 12'd80;
  localparam logic [MARGIN_W-1:0] RMARG_RST  = 12'd60;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    image_height;
    logic [RADIUS_W-1:0] lens_radius;
    logic [MARGIN_W-1:0] col_margin;
    logic [MARGIN_W-1:0] row_margin;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_col;
    logic [NUM_W-1:0] num_row;
    logic             neg_col;
    logic             neg_row;
    logic             ok;
  } front_sb_t;

endpackage

@@ rtl/core/fdag_if.sv @@
// Channel interfaces of the fisheye dewarp address generator.
// Depends on nothing; field widths follow the package.
interface fdag_in_if;
  logic        valid;
  logic        ready;
  logic [12:0] out_col;
  logic [12:0] out_row;
  modport source(output valid, output out_col, output out_row, input ready);
  modport sink(input valid, input out_col, input out_row, output ready);
endinterface

interface fdag_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] src_col;
  logic [11:0] src_row;
  logic        in_range;
  modport source(output valid, output src_col, output src_row, output in_range, input ready);
  modport sink(input valid, input src_col, input src_row, input in_range, output ready);
endinterface

@@ rtl/core/fdag_front.sv @@
// Front stages: margin removal, squares and the radicand Q.
// Depends on fdag_pkg.
module fdag_front #(
  parameter int MAX_DIM = fdag_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  fdag_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  input  logic [fdag_pkg::POS_W-1:0]         in_col,
  input  logic [fdag_pkg::POS_W-1:0]         in_row,
  output logic                               out_valid,
  output logic [fdag_pkg::RAD_IN_W-1:0]      out_v,
  output fdag_pkg::front_sb_t                out_sb
);
  import fdag_pkg::*;

  logic                    v1, v2;
  logic signed [OFF_W-1:0] a1, b1;
  logic                    g1, g2;
  logic [2*MAG_W-1:0]      asq2, bsq2;
  logic [35:0]             rsq2;
  logic [2*DIM_W-1:0]      wsq2;
  logic [NUM_W-1:0]        na2, nb2;
  logic                    sa2, sb2;
  logic [MAG_W-1:0]        ma, mb;
  logic signed [36:0]      q;

  assign ma = a1[OFF_W-1] ? MAG_W'(-a1) : MAG_W'(a1);
  assign mb = b1[OFF_W-1] ? MAG_W'(-b1) : MAG_W'(b1);
  assign q  = $signed(37'(asq2)) + $signed(37'(bsq2)) + $signed(37'(rsq2))
            - $signed(37'(wsq2));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= $signed({2'b0, in_col, 1'b0}) - $signed({3'b0, cfg.col_margin, 1'b0})
          - $signed({3'b0, cfg.frame_width});
      b1 <= $signed({2'b0, in_row, 1'b0}) - $signed({3'b0, cfg.row_margin, 1'b0})
          - $signed({3'b0, cfg.image_height});
      g1 <= ({cfg.lens_radius, 1'b0} > {4'b0, cfg.frame_width})
          && (32'(cfg.frame_width) <= 32'(MAX_DIM))
          && (32'(cfg.image_height) <= 32'(MAX_DIM));
      asq2 <= ma * ma;
      bsq2 <= mb * mb;
      rsq2 <= {2'b0, NUM_W'(cfg.lens_radius) * NUM_W'(cfg.lens_radius), 2'b0};
      wsq2 <= cfg.frame_width * cfg.frame_width;
      na2  <= NUM_W'(cfg.lens_radius) * NUM_W'(ma);
      nb2  <= NUM_W'(cfg.lens_radius) * NUM_W'(mb);
      sa2  <= a1[OFF_W-1];
      sb2  <= b1[OFF_W-1];
      g2   <= g1;
      out_v <= (q > 0) ? RAD_IN_W'(q[35:0]) : '0;
      out_sb.num_col <= na2;
      out_sb.num_row <= nb2;
      out_sb.neg_col <= sa2;
      out_sb.neg_row <= sb2;
      out_sb.ok      <= g2 && (q > 0);
    end
  end

endmodule

@@ rtl/core/fdag_sqrt.sv @@
// Pipelined square root, one result bit per stage, rounded to nearest.
// Depends on fdag_pkg.
module fdag_sqrt #(
  parameter int FRAC_BITS = fdag_pkg::FRAC_BITS_DEF,
  parameter int SB_W      = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [fdag_pkg::RAD_IN_W-1:0]     in_v,
  input  logic [SB_W-1:0]                   in_sb,
  output logic                              out_valid,
  output logic [fdag_pkg::RAD_IN_W/2+FRAC_BITS-1:0] out_root,
  output logic [SB_W-1:0]                   out_sb
);
  import fdag_pkg::*;

  localparam int STEPS = RAD_IN_W/2 + FRAC_BITS;
  localparam int RW    = STEPS;
  localparam int RMW   = RW + 3;

  logic              vld  [0:STEPS];
  logic [RAD_IN_W-1:0] rad [0:STEPS];
  logic [RW-1:0]     root [0:STEPS];
  logic [RMW-1:0]    rem  [0:STEPS];
  logic [SB_W-1:0]   sb   [0:STEPS];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_v;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign sb[0]   = in_sb;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RMW-1:0] rem_sh, trial;
    logic           ge;
    assign rem_sh = {rem[k][RMW-3:0], rad[k][RAD_IN_W-1 -: 2]};
    assign trial  = RMW'({root[k], 2'b01});
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= {rad[k][RAD_IN_W-3:0], 2'b00};
        root[k+1] <= {root[k][RW-2:0], ge};
        rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sb[k+1]   <= sb[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_root <= root[STEPS] + RW'(rem[STEPS] > RMW'(root[STEPS]));
      out_sb   <= sb[STEPS];
    end
  end

endmodule

@@ rtl/core/fdag_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, ties to even.
// Depends on fdag_pkg.
module fdag_div #(
  parameter int FRAC_BITS = fdag_pkg::FRAC_BITS_DEF,
  parameter int SB_W      = 1
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic [fdag_pkg::NUM_W-1:0]                  in_num,
  input  logic [fdag_pkg::RAD_IN_W/2+FRAC_BITS-1:0]   in_den,
  input  logic [SB_W-1:0]                             in_sb,
  output logic                                        out_valid,
  output logic [fdag_pkg::NUM_W+2*FRAC_BITS-1:0]      out_quo,
  output logic [SB_W-1:0]                             out_sb
);
  import fdag_pkg::*;

  localparam int STEPS = NUM_W + 2*FRAC_BITS;
  localparam int QW    = STEPS;
  localparam int RW    = RAD_IN_W/2 + FRAC_BITS;

  logic             vld [0:STEPS];
  logic [NUM_W-1:0] num [0:STEPS];
  logic [RW-1:0]    den [0:STEPS];
  logic [RW-1:0]    rem [0:STEPS];
  logic [QW-1:0]    quo [0:STEPS];
  logic [SB_W-1:0]  sb  [0:STEPS];

  assign vld[0] = in_valid;
  assign num[0] = in_num;
  assign den[0] = in_den;
  assign rem[0] = '0;
  assign quo[0] = '0;
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RW:0] rem_sh, diff;
    logic        ge;
    assign rem_sh = {rem[k], num[k][NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den[k]};
    assign diff   = rem_sh - {1'b0, den[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1] <= {num[k][NUM_W-2:0], 1'b0};
        den[k+1] <= den[k];
        rem[k+1] <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
        quo[k+1] <= {quo[k][QW-2:0], ge};
        sb[k+1]  <= sb[k];
      end
    end
  end

  logic [RW:0] twice;
  logic        up;
  assign twice = {rem[STEPS], 1'b0};
  assign up    = (twice > {1'b0, den[STEPS]})
              || ((twice == {1'b0, den[STEPS]}) && quo[STEPS][0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quo <= quo[STEPS] + QW'(up);
      out_sb  <= sb[STEPS];
    end
  end

endmodule

@@ rtl/core/fdag_place.sv @@
// Final stages: source position, strict range test and rounding to a pixel.
// Depends on fdag_pkg.
module fdag_place #(
  parameter int FRAC_BITS = fdag_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  fdag_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  input  logic [fdag_pkg::NUM_W+2*FRAC_BITS-1:0] off_col,
  input  logic [fdag_pkg::NUM_W+2*FRAC_BITS-1:0] off_row,
  input  logic                                   neg_col,
  input  logic                                   neg_row,
  input  logic                                   ok,
  output logic                                   out_valid,
  output logic [fdag_pkg::COORD_W-1:0]           src_col,
  output logic [fdag_pkg::COORD_W-1:0]           src_row,
  output logic                                   in_range
);
  import fdag_pkg::*;

  localparam int QW = NUM_W + 2*FRAC_BITS;
  localparam int PW = QW + 2;

  logic signed [PW-1:0] ctr_c, ctr_r, pc, pr, hi_c, hi_r;
  logic                 v1, ok1;
  logic                 inc, inr, upc, upr;
  logic [FRAC_BITS-1:0] half;

  assign ctr_c = $signed(PW'(cfg.frame_width)) <<< (FRAC_BITS-1);
  assign ctr_r = $signed(PW'(cfg.image_height)) <<< (FRAC_BITS-1);
  assign hi_c  = ($signed(PW'(cfg.frame_width)) - $signed(PW'(1))) <<< FRAC_BITS;
  assign hi_r  = ($signed(PW'(cfg.image_height)) - $signed(PW'(1))) <<< FRAC_BITS;
  assign half  = FRAC_BITS'(1) << (FRAC_BITS-1);

  assign inc = (pc > 0) && (pc < hi_c);
  assign inr = (pr > 0) && (pr < hi_r);
  assign upc = (pc[FRAC_BITS-1:0] > half)
            || ((pc[FRAC_BITS-1:0] == half) && pc[FRAC_BITS]);
  assign upr = (pr[FRAC_BITS-1:0] > half)
            || ((pr[FRAC_BITS-1:0] == half) && pr[FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc  <= neg_col ? ctr_c - $signed(PW'(off_col)) : ctr_c + $signed(PW'(off_col));
      pr  <= neg_row ? ctr_r - $signed(PW'(off_row)) : ctr_r + $signed(PW'(off_row));
      ok1 <= ok;
      in_range <= ok1 && inc && inr;
      src_col  <= (ok1 && inc && inr)
                ? pc[FRAC_BITS +: COORD_W] + COORD_W'(upc) : '0;
      src_row  <= (ok1 && inc && inr)
                ? pr[FRAC_BITS +: COORD_W] + COORD_W'(upr) : '0;
    end
  end

endmodule

@@ rtl/core/fisheye_dewarp_address_gen.sv @@
// Fisheye dewarp address generator, top level.
// Maps each output pixel position on the pix channel to a source pixel on
// the src channel. Both channels use valid/ready; an item moves when both
// are high. Configuration is written through cfg_we, cfg_index and cfg_data
// while no item is in flight, a rule for the user that the block does not
// enforce. Registers are image width, image height, lens radius, column
// margin and row margin, at indexes 0 to 4. The pipeline accepts one item
// per cycle while the output is not stalled. An item passes through the
// front stages, then the square root, the division and the placement
// stages; the divider, with one stage per quotient bit, is the longest part.
// The whole pipeline advances together; when the receiver holds ready low
// with a result waiting, every stage holds and pix.ready falls, so nothing
// is lost or repeated. Reset clears all valid bits and loads the default
// configuration (640 by 480 frame, radius 1500, margins 80 and 60).
// Results with in_range low carry zero coordinates.
// Depends on fdag_pkg, fdag_if and the fdag_* pipeline modules.
module fisheye_dewarp_address_gen #(
  parameter int MAX_DIM   = fdag_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = fdag_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  fdag_in_if.sink                         pix,
  fdag_out_if.source                      src,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [fdag_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdag_pkg::*;

  localparam int RW = RAD_IN_W/2 + FRAC_BITS;
  localparam int QW = NUM_W + 2*FRAC_BITS;
  localparam int SBW = $bits(front_sb_t);

  cfg_t                cfg;
  logic                en;
  logic                f_valid, s_valid, dc_valid, dr_valid;
  logic [RAD_IN_W-1:0] f_v;
  front_sb_t           f_sb, s_sb;
  logic [RW-1:0]       root;
  logic [QW-1:0]       off_c, off_r;
  logic [2:0]          dc_sb;
  logic                dr_sb;

  assign en        = !src.valid || src.ready;
  assign pix.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= WIDTH_RST;
      cfg.image_height <= HEIGHT_RST;
      cfg.lens_radius  <= RADIUS_RST;
      cfg.col_margin   <= CMARG_RST;
      cfg.row_margin   <= RMARG_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[DIM_W-1:0];
        REG_LENS_RADIUS:  cfg.lens_radius  <= cfg_data[RADIUS_W-1:0];
        REG_COL_MARGIN:   cfg.col_margin   <= cfg_data[MARGIN_W-1:0];
        REG_ROW_MARGIN:   cfg.row_margin   <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  fdag_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(pix.valid), .in_col(pix.out_col), .in_row(pix.out_row),
    .out_valid(f_valid), .out_v(f_v), .out_sb(f_sb)
  );

  fdag_sqrt #(.FRAC_BITS(FRAC_BITS), .SB_W(SBW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_valid), .in_v(f_v), .in_sb(f_sb),
    .out_valid(s_valid), .out_root(root), .out_sb(s_sb)
  );

  fdag_div #(.FRAC_BITS(FRAC_BITS), .SB_W(3)) u_div_col (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_valid), .in_num(s_sb.num_col), .in_den(root),
    .in_sb({s_sb.neg_col, s_sb.neg_row, s_sb.ok && (root != '0)}),
    .out_valid(dc_valid), .out_quo(off_c), .out_sb(dc_sb)
  );

  fdag_div #(.FRAC_BITS(FRAC_BITS), .SB_W(1)) u_div_row (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_valid), .in_num(s_sb.num_row), .in_den(root),
    .in_sb(s_valid),
    .out_valid(dr_valid), .out_quo(off_r), .out_sb(dr_sb)
  );

  fdag_place #(.FRAC_BITS(FRAC_BITS)) u_place (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(dc_valid && dr_valid && dr_sb),
    .off_col(off_c), .off_row(off_r),
    .neg_col(dc_sb[2]), .neg_row(dc_sb[1]), .ok(dc_sb[0]),
    .out_valid(src.valid), .src_col(src.src_col), .src_row(src.src_row),
    .in_range(src.in_range)
  );

`ifndef SYNTHESIS
  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    src.valid && !src.in_range |-> (src.src_col == '0) && (src.src_row == '0))
    else $error("out of range result carries nonzero coordinates");

  a_bad_lens: assert property (@(posedge clk) disable iff (rst)
    src.valid && ({cfg.lens_radius, 1'b0} <= {4'b0, cfg.frame_width}) |-> !src.in_range)
    else $error("in range flagged with invalid lens geometry");

  a_dividers_aligned: assert property (@(posedge clk) disable iff (rst)
    dc_valid == dr_valid)
    else $error("column and row dividers out of step");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    src.valid && !src.ready |=> $stable(dc_valid) && $stable(off_c))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule
